@@ design/afpt_pkg.sv @@
// Shared types, codes and default sizes for the frame point transform.
package afpt_pkg;

  // Default sizes of coordinates, their fraction and the axis coefficients.
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int COEFF_WIDTH_DEF = 18;

  // Transform commands carried in the input tuser.
  typedef enum logic [1:0] {
    CMD_POINT_TO_WORLD  = 2'd0,
    CMD_POINT_TO_LOCAL  = 2'd1,
    CMD_VECTOR_TO_WORLD = 2'd2,
    CMD_VECTOR_TO_LOCAL = 2'd3
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_AXIS_X   = 3'd0,
    CFG_AXIS_Y   = 3'd1,
    CFG_AXIS_Z   = 3'd2,
    CFG_ORIGIN_X = 3'd3,
    CFG_ORIGIN_Y = 3'd4,
    CFG_ORIGIN_Z = 3'd5
  } cfg_idx_t;

endpackage

@@ design/axis_frame_point_transform.sv @@
// Streaming transform of 3D points and vectors between world and a local frame.
//
//   Channel | Direction | Handshake             | Payload
//   in_     | slave     | in_tvalid/in_tready   | tdata {z,y,x}, tuser cmd
//   out_    | master    | out_tvalid/out_tready | tdata {z,y,x}, tuser status
//   cfg_    | slave     | cfg_valid/cfg_ready   | cfg_addr index, cfg_data value
//
// Four register stages (origin subtract, nine products, sums, range check).
// The edge that accepts an item loads the first stage; the item then moves
// on through the product, sum and range-check registers to out_tvalid.
// One item per cycle is sustained while out_tready is high; each stage has
// its own valid bit, so a stalled output only holds the full stages behind it.
// rst_n is synchronous and clears the valid bits and restores the unit frame.
// cfg_ready is always high; writes are expected only while no item is in flight.
module axis_frame_point_transform #(
  parameter int COORD_WIDTH = afpt_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = afpt_pkg::FRAC_BITS_DEF,
  parameter int COEFF_WIDTH = afpt_pkg::COEFF_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // Input items.
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // Fields from bit 0: in_x, in_y, in_z, zero pad to whole bytes.
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]         in_tdata,
  // Fields from bit 0: cmd.
  input  afpt_pkg::cmd_t                             in_tuser,
  // Result items.
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // Fields from bit 0: out_x, out_y, out_z, zero pad to whole bytes.
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]         out_tdata,
  // Fields from bit 0: status.
  output logic                                       out_tuser,
  // Configuration writes.
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  afpt_pkg::cfg_idx_t                         cfg_addr,
  input  logic [((3*COEFF_WIDTH > COORD_WIDTH) ? 3*COEFF_WIDTH : COORD_WIDTH)-1:0] cfg_data
);
  import afpt_pkg::*;

  // The fraction width names the coordinate format only; it sets no hardware.
  localparam int DATA_W  = ((3*COORD_WIDTH+7)/8)*8;
  localparam int CFRAC   = COEFF_WIDTH - 2;
  localparam int AXIS_W  = 3*COEFF_WIDTH;
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = DIFF_W + COEFF_WIDTH;
  localparam int TERM_W  = PROD_W - CFRAC;
  localparam int SUM_W   = TERM_W + 2;
  localparam int TOP_W   = SUM_W - COORD_WIDTH + 1;

  // Unit coefficient 1.0 in Q2 format.
  localparam logic [COEFF_WIDTH-1:0] COEFF_ONE = COEFF_WIDTH'(1) << CFRAC;

  // Frame registers.
  logic [AXIS_W-1:0]             axis_r   [3];
  logic signed [COORD_WIDTH-1:0] origin_r [3];

  assign cfg_ready = 1'b1;

  // Configuration write decode; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r[0]   <= AXIS_W'(COEFF_ONE);
      axis_r[1]   <= AXIS_W'(COEFF_ONE) << COEFF_WIDTH;
      axis_r[2]   <= AXIS_W'(COEFF_ONE) << (2*COEFF_WIDTH);
      origin_r[0] <= '0;
      origin_r[1] <= '0;
      origin_r[2] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        CFG_AXIS_X:   axis_r[0]   <= cfg_data[AXIS_W-1:0];
        CFG_AXIS_Y:   axis_r[1]   <= cfg_data[AXIS_W-1:0];
        CFG_AXIS_Z:   axis_r[2]   <= cfg_data[AXIS_W-1:0];
        CFG_ORIGIN_X: origin_r[0] <= $signed(cfg_data[COORD_WIDTH-1:0]);
        CFG_ORIGIN_Y: origin_r[1] <= $signed(cfg_data[COORD_WIDTH-1:0]);
        CFG_ORIGIN_Z: origin_r[2] <= $signed(cfg_data[COORD_WIDTH-1:0]);
        default: ;
      endcase
    end
  end

  // Per-stage valid bits and the ready chain from the output back.
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Command decode at the input.
  logic to_local, is_point;
  assign to_local = (in_tuser == CMD_POINT_TO_LOCAL) || (in_tuser == CMD_VECTOR_TO_LOCAL);
  assign is_point = (in_tuser == CMD_POINT_TO_WORLD) || (in_tuser == CMD_POINT_TO_LOCAL);

  // Stage 1: unpack the item and subtract the origin for points going to local.
  logic signed [DIFF_W-1:0] diff_nxt [3];
  logic signed [DIFF_W-1:0] diff_r   [3];
  logic                     local1_r, addorg1_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_nxt[i] = DIFF_W'($signed(in_tdata[i*COORD_WIDTH +: COORD_WIDTH]));
      if (to_local && is_point) begin
        diff_nxt[i] = diff_nxt[i] - DIFF_W'(origin_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      diff_r    <= diff_nxt;
      local1_r  <= to_local;
      addorg1_r <= is_point && !to_local;
    end
  end

  // Stage 2: nine products, each floored by the coefficient fraction.
  // Going to world row i takes component i of every axis; going to local
  // row i takes every component of axis i.
  logic signed [COEFF_WIDTH-1:0] coef   [3][3];
  logic signed [PROD_W-1:0]      prod   [3][3];
  logic signed [TERM_W-1:0]      term_r [3][3];
  logic                          addorg2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef[i][j] = local1_r ? $signed(axis_r[i][j*COEFF_WIDTH +: COEFF_WIDTH])
                              : $signed(axis_r[j][i*COEFF_WIDTH +: COEFF_WIDTH]);
        prod[i][j] = diff_r[j] * coef[i][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          term_r[i][j] <= $signed(prod[i][j][PROD_W-1:CFRAC]);
        end
      end
      addorg2_r <= addorg1_r;
    end
  end

  // Stage 3: sum each row, adding the origin for points going to world.
  logic signed [SUM_W-1:0] sum_nxt [3];
  logic signed [SUM_W-1:0] sum_r   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_nxt[i] = SUM_W'(term_r[i][0]) + SUM_W'(term_r[i][1]) + SUM_W'(term_r[i][2]);
      if (addorg2_r) begin
        sum_nxt[i] = sum_nxt[i] + SUM_W'(origin_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      sum_r <= sum_nxt;
    end
  end

  // Stage 4: range check; any component out of range zeroes the whole result.
  logic [TOP_W-1:0]  top_bits [3];
  logic              ovf_nxt;
  logic [DATA_W-1:0] data_nxt;
  logic [DATA_W-1:0] data_r;
  logic              status_r;

  always_comb begin
    ovf_nxt  = 1'b0;
    data_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      top_bits[i] = sum_r[i][SUM_W-1:COORD_WIDTH-1];
      if (!((&top_bits[i]) || !(|top_bits[i]))) begin
        ovf_nxt = 1'b1;
      end
      data_nxt[i*COORD_WIDTH +: COORD_WIDTH] = sum_r[i][COORD_WIDTH-1:0];
    end
    if (ovf_nxt) begin
      data_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      data_r   <= data_nxt;
      status_r <= ovf_nxt;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = data_r;
  assign out_tuser  = status_r;

endmodule

@@ design/afpt_checker.sv @@
// Port-level checks for the frame point transform, bound to the top level.
module afpt_checker #(
  parameter int COORD_WIDTH = afpt_pkg::COORD_WIDTH_DEF,
  parameter int COEFF_WIDTH = afpt_pkg::COEFF_WIDTH_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [((3*COORD_WIDTH+7)/8)*8-1:0]  out_tdata,
  input logic                                out_tuser,
  input logic                                cfg_valid,
  input logic                                cfg_ready
);

  // A stalled result keeps its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  // An overflowing result carries all-zero coordinates.
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("overflow result with nonzero coordinates");

  // With the output free, the pipeline always takes a new item.
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled while the output could drain");

  // Reset empties the pipeline and configuration is always taken.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && (!cfg_valid || cfg_ready))
    else $error("result valid after reset or configuration write refused");

endmodule

bind axis_frame_point_transform afpt_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .COEFF_WIDTH(COEFF_WIDTH)
) u_afpt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

@@ test/axis_frame_point_transform_tb.sv @@
// Self-checking testbench for the streaming world/local frame point transform.
module axis_frame_point_transform_tb;
  import afpt_pkg::*;

  localparam int CW    = COORD_WIDTH_DEF;
  localparam int KW    = COEFF_WIDTH_DEF;
  localparam int KFRAC = KW - 2;
  localparam int TDW   = ((3*CW+7)/8)*8;
  localparam int CDW   = (3*KW > CW) ? 3*KW : CW;

  // Indexes past the last register; writes to them must change nothing.
  localparam cfg_idx_t CFG_SPARE_6 = cfg_idx_t'(3'd6);
  localparam cfg_idx_t CFG_SPARE_7 = cfg_idx_t'(3'd7);

  localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [KW-1:0] COEFF_MAX = {1'b0, {(KW-1){1'b1}}};
  localparam logic [KW-1:0] COEFF_MIN = {1'b1, {(KW-1){1'b0}}};
  localparam logic [KW-1:0] COEFF_ONE = KW'(1 << KFRAC);

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic          ovf;
  } coord_result_t;

  // Holds a copy of the frame registers and the results still owed by the block.
  class transform_checker;
    logic [3*KW-1:0] axis [3];
    logic [CW-1:0]   origin [3];
    coord_result_t   owed_results [$];
    int              errors;

    function new();
      for (int i = 0; i < 3; i++) begin
        axis[i] = '0;
        axis[i][i*KW + KFRAC] = 1'b1;
        origin[i] = '0;
      end
      errors = 0;
    endfunction

    // Mirror a register write; upper bits beyond a register's width are dropped.
    function void write_reg(cfg_idx_t idx, logic [CDW-1:0] data);
      case (idx)
        CFG_AXIS_X:   axis[0] = data[3*KW-1:0];
        CFG_AXIS_Y:   axis[1] = data[3*KW-1:0];
        CFG_AXIS_Z:   axis[2] = data[3*KW-1:0];
        CFG_ORIGIN_X: origin[0] = data[CW-1:0];
        CFG_ORIGIN_Y: origin[1] = data[CW-1:0];
        CFG_ORIGIN_Z: origin[2] = data[CW-1:0];
        default: ;
      endcase
    endfunction

    function longint coord_val(logic [CW-1:0] w);
      logic signed [CW-1:0] s;
      s = w;
      return s;
    endfunction

    function longint coeff_val(int a, int k);
      logic signed [KW-1:0] s;
      s = axis[a][k*KW +: KW];
      return s;
    endfunction

    // Product truncated toward minus infinity back to the coordinate format.
    function longint scale(longint v, longint c);
      return (v * c) >>> KFRAC;
    endfunction

    function coord_result_t predict_transform(cmd_t cmd, logic [CW-1:0] xi,
                                              logic [CW-1:0] yi, logic [CW-1:0] zi);
      longint        v [3];
      longint        r [3];
      longint        lim_hi;
      longint        lim_lo;
      logic          to_local;
      logic          is_point;
      logic          ovf;
      coord_result_t res;
      to_local = (cmd == CMD_POINT_TO_LOCAL) || (cmd == CMD_VECTOR_TO_LOCAL);
      is_point = (cmd == CMD_POINT_TO_WORLD) || (cmd == CMD_POINT_TO_LOCAL);
      lim_hi = (longint'(1) << (CW-1)) - 1;
      lim_lo = -(longint'(1) << (CW-1));
      v[0] = coord_val(xi);
      v[1] = coord_val(yi);
      v[2] = coord_val(zi);
      if (to_local) begin
        // The difference is kept exact, one bit wider than a coordinate.
        if (is_point)
          for (int i = 0; i < 3; i++) v[i] = v[i] - coord_val(origin[i]);
        for (int i = 0; i < 3; i++)
          r[i] = scale(v[0], coeff_val(i, 0)) + scale(v[1], coeff_val(i, 1)) +
                 scale(v[2], coeff_val(i, 2));
      end else begin
        for (int i = 0; i < 3; i++) begin
          r[i] = scale(v[0], coeff_val(0, i)) + scale(v[1], coeff_val(1, i)) +
                 scale(v[2], coeff_val(2, i));
          if (is_point) r[i] = r[i] + coord_val(origin[i]);
        end
      end
      ovf = 1'b0;
      for (int i = 0; i < 3; i++)
        if (r[i] > lim_hi || r[i] < lim_lo) ovf = 1'b1;
      res.x   = ovf ? '0 : r[0][CW-1:0];
      res.y   = ovf ? '0 : r[1][CW-1:0];
      res.z   = ovf ? '0 : r[2][CW-1:0];
      res.ovf = ovf;
      return res;
    endfunction

    function void note_item(cmd_t cmd, logic [TDW-1:0] data);
      owed_results.push_back(predict_transform(cmd, data[0 +: CW], data[CW +: CW],
                                               data[2*CW +: CW]));
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [TDW-1:0] data, logic status);
      coord_result_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("result item with none expected, tdata %h", data));
      end else begin
        want = owed_results.pop_front();
        if (data[0 +: CW] !== want.x)
          report($sformatf("out_x got %h expected %h", data[0 +: CW], want.x));
        if (data[CW +: CW] !== want.y)
          report($sformatf("out_y got %h expected %h", data[CW +: CW], want.y));
        if (data[2*CW +: CW] !== want.z)
          report($sformatf("out_z got %h expected %h", data[2*CW +: CW], want.z));
        if (status !== want.ovf)
          report($sformatf("status got %b expected %b", status, want.ovf));
      end
    endtask
  endclass

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_tvalid = 1'b0;
  logic           in_tready;
  logic [TDW-1:0] in_tdata = '0;
  cmd_t           in_tuser = CMD_POINT_TO_WORLD;
  logic           out_tvalid;
  logic           out_tready = 1'b0;
  logic [TDW-1:0] out_tdata;
  logic           out_tuser;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  cfg_idx_t       cfg_addr = CFG_AXIS_X;
  logic [CDW-1:0] cfg_data = '0;

  int in_idle_pct  = 30;
  int out_idle_pct = 30;

  transform_checker frame_check = new();

  axis_frame_point_transform dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // Watch all three handshakes at the edge where they complete.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) frame_check.write_reg(cfg_addr, cfg_data);
      if (in_tvalid && in_tready) frame_check.note_item(in_tuser, in_tdata);
      if (out_tvalid && out_tready) frame_check.check_result(out_tdata, out_tuser);
    end
  end

  // Offer one item, after random idle cycles, and hold it until it is taken.
  task automatic send_item(cmd_t cmd, logic [CW-1:0] x, logic [CW-1:0] y,
                           logic [CW-1:0] z);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= TDW'({z, y, x});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering items and wait until every result has come back; the
  // first edge lets the monitor note the last accepted item.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (frame_check.owed_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CDW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write the whole frame; origin writes carry junk in the unused upper bits.
  task automatic load_frame(logic [3*KW-1:0] ax, logic [3*KW-1:0] ay,
                            logic [3*KW-1:0] az, logic [CW-1:0] ox,
                            logic [CW-1:0] oy, logic [CW-1:0] oz);
    write_reg(CFG_AXIS_X, CDW'(ax));
    write_reg(CFG_AXIS_Y, CDW'(ay));
    write_reg(CFG_AXIS_Z, CDW'(az));
    write_reg(CFG_ORIGIN_X, CDW'({CDW'({$urandom, $urandom}) >> CW, ox}));
    write_reg(CFG_ORIGIN_Y, CDW'({CDW'({$urandom, $urandom}) >> CW, oy}));
    write_reg(CFG_ORIGIN_Z, CDW'({CDW'({$urandom, $urandom}) >> CW, oz}));
    if ($urandom_range(0, 1) == 0) write_reg(CFG_SPARE_6, CDW'({$urandom, $urandom}));
    if ($urandom_range(0, 1) == 0) write_reg(CFG_SPARE_7, CDW'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
  endtask

  // Coefficient styles: 0 any, 1 within plus or minus one, 2 extremes, 3 mixed.
  function automatic logic [KW-1:0] rand_coeff(int mode);
    int m;
    m = (mode == 3) ? $urandom_range(0, 2) : mode;
    case (m)
      0: return KW'($urandom);
      1: return KW'($urandom_range(0, 2 << KFRAC) - (1 << KFRAC));
      default:
        case ($urandom_range(0, 3))
          0: return COEFF_MAX;
          1: return COEFF_MIN;
          2: return '0;
          default: return COEFF_ONE;
        endcase
    endcase
  endfunction

  function automatic logic [3*KW-1:0] rand_axis(int mode);
    return {rand_coeff(mode), rand_coeff(mode), rand_coeff(mode)};
  endfunction

  // Coordinate styles: 0 any, 1 small, 2 extremes, 3 mixed.
  function automatic logic [CW-1:0] rand_coord(int mode);
    int m;
    m = (mode == 3) ? (($urandom_range(0, 9) < 4) ? 1 :
                       ($urandom_range(0, 9) < 7) ? 0 : 2) : mode;
    case (m)
      0: return CW'($urandom);
      1: return CW'($urandom_range(0, 1 << 21) - (1 << 20));
      default:
        case ($urandom_range(0, 3))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return '0;
          default: return '1;
        endcase
    endcase
  endfunction

  initial begin
    int n_items;
    int mode;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset frame: extremes pass through unchanged for every command.
    for (int c = 0; c < 4; c++) begin
      send_item(cmd_t'(c), COORD_MAX, COORD_MAX, COORD_MAX);
      send_item(cmd_t'(c), COORD_MIN, COORD_MIN, COORD_MIN);
      send_item(cmd_t'(c), '0, CW'(1), '1);
    end
    drain_results();

    // Extreme frame: overflow on large inputs, origin alone on a zero point to world.
    load_frame({COEFF_MAX, COEFF_MAX, COEFF_MAX}, {COEFF_MIN, COEFF_MIN, COEFF_MIN},
               {COEFF_MAX, KW'(0), COEFF_MIN}, COORD_MAX, COORD_MIN, '0);
    for (int c = 0; c < 4; c++) begin
      send_item(cmd_t'(c), COORD_MAX, COORD_MIN, COORD_MAX);
      send_item(cmd_t'(c), '0, '0, '0);
      send_item(cmd_t'(c), CW'(1), '1, CW'(1));
    end
    drain_results();

    // Random phases, each under its own frame; one phase runs without stalls.
    for (int p = 0; p < 8; p++) begin
      mode = p % 4;
      load_frame(rand_axis(mode), rand_axis(mode), rand_axis(mode),
                 rand_coord(mode == 1 ? 1 : mode == 2 ? 2 : 3),
                 rand_coord(mode == 1 ? 1 : mode == 2 ? 2 : 3),
                 rand_coord(mode == 1 ? 1 : mode == 2 ? 2 : 3));
      in_idle_pct  = (p == 3) ? 0 : 30;
      out_idle_pct = (p == 3) ? 0 : 30;
      n_items = (p == 3) ? 300 : 140;
      for (int i = 0; i < n_items; i++)
        send_item(cmd_t'($urandom_range(0, 3)), rand_coord(3), rand_coord(3),
                  rand_coord(3));
      drain_results();
    end

    in_idle_pct  = 30;
    out_idle_pct = 30;
    repeat (10) @(posedge clk);
    if (frame_check.errors == 0) begin
      $display("axis_frame_point_transform_tb: PASS");
    end else begin
      $display("axis_frame_point_transform_tb: FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("axis_frame_point_transform_tb: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
design/afpt_pkg.sv
design/axis_frame_point_transform.sv
design/afpt_checker.sv
test/axis_frame_point_transform_tb.sv
